>>> rtl/core/mesh_vertex_weld_core_assert.svh
// Assertion macros for the vertex weld core.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef MESH_VERTEX_WELD_CORE_ASSERT_SVH
`define MESH_VERTEX_WELD_CORE_ASSERT_SVH

// Same-cycle implication.
`define MVW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MVW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mvw_pkg.sv
// Shared types and constants of the vertex weld core.
// No dependencies; the core modules that use it refer to it by scoped names.
`default_nettype none

package mvw_pkg;

    localparam int COORD_W      = 32;
    localparam int TOL_W        = 31;
    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int RANK_W       = 5;
    localparam int SQ_W         = 2 * TOL_W;
    localparam int SUM_W        = SQ_W + 2;

    localparam logic [TOL_W-1:0] TOL_RESET  = TOL_W'(65536);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_VERTICES);
    localparam logic [RANK_W-1:0] RANK_NONE = RANK_W'(27);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } mvw_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } mvw_entry_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } mvw_tag_t;

    typedef struct packed {
        logic             busy;
        logic             found;
        logic [IDX_W-1:0] idx;
    } mvw_best_t;

    function automatic logic unit_offset(input logic [COORD_W:0] v);
        unit_offset = (v == '0) || (v == (COORD_W + 1)'(1)) || (v == '1);
    endfunction

    function automatic logic [COORD_W:0] abs_diff(input logic [COORD_W:0] d);
        abs_diff = d[COORD_W] ? ((COORD_W + 1)'(0) - d) : d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mesh_vertex_weld_core.sv
// Top level of the vertex weld core: control sequencer, vertex store, result port.
// Depends on mvw_pkg, mvw_ram, mvw_div, mvw_match and the assertion header.
//
// Usage:
//   A point (x_coord, y_coord, z_coord) transfers at a rising edge with start
//   high and busy low. busy stays high until the result has been produced.
//   One result per point is shown for exactly one cycle with result_valid high:
//   vertex_index, is_new and store_full. The receiver cannot stall; the result
//   is taken in the cycle it is shown.
//   weld_tolerance is written when weld_tolerance_we is high. The user must
//   write it only while idle; the block itself does not enforce this.
//   A point passes through the three parallel bit-serial floor dividers that
//   form the cell keys, then the vertex-store reads, the drain of the match
//   pipeline and a commit. busy drops with the result strobe, so no new point
//   is taken before the result of the last one is shown.
//   Reset empties the store (vertex count zero) and sets the tolerance to 1.0;
//   no clearing pass is needed.
`default_nettype none

`include "mesh_vertex_weld_core_assert.svh"

module mesh_vertex_weld_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mvw_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mvw_pkg::COORD_W-1:0] y_coord,
    input  logic signed [mvw_pkg::COORD_W-1:0] z_coord,
    input  logic                               weld_tolerance_we,
    input  logic [mvw_pkg::TOL_W-1:0]          weld_tolerance,
    output logic                               result_valid,
    output logic [mvw_pkg::IDX_W-1:0]          vertex_index,
    output logic                               is_new,
    output logic                               store_full
);

    mvw_pkg::mvw_state_t state_reg, state_next;

    logic [mvw_pkg::TOL_W-1:0]  weld_tolerance_reg;
    logic [mvw_pkg::TOL_W-1:0]  tol_eff;
    logic [mvw_pkg::TOL_W-1:0]  tol_reg;
    logic [mvw_pkg::SQ_W-1:0]   tol2_reg;
    logic [mvw_pkg::CNT_W-1:0]  count_reg;
    logic [mvw_pkg::CNT_W-1:0]  rd_idx_reg;
    mvw_pkg::mvw_tag_t          tag_reg;

    logic signed [mvw_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [mvw_pkg::COORD_W-1:0] cx, cy, cz;
    logic                               done_x, done_y, done_z;

    logic                         result_valid_reg;
    logic [mvw_pkg::IDX_W-1:0]    vertex_index_reg;
    logic                         is_new_reg;
    logic                         store_full_reg;

    logic                 accept;
    logic                 issue;
    logic                 commit;
    logic                 full;
    logic                 mem_we;
    mvw_pkg::mvw_entry_t  point;
    mvw_pkg::mvw_entry_t  rd_entry;
    mvw_pkg::mvw_best_t   best;

    assign busy    = (state_reg != mvw_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign tol_eff = (weld_tolerance_reg == '0) ? mvw_pkg::TOL_W'(1) : weld_tolerance_reg;
    assign full    = (count_reg == mvw_pkg::CNT_FULL);

    assign point.x  = px_reg;
    assign point.y  = py_reg;
    assign point.z  = pz_reg;
    assign point.cx = cx;
    assign point.cy = cy;
    assign point.cz = cz;

    mvw_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (x_coord),
        .divisor  (tol_eff),
        .done     (done_x),
        .quotient (cx)
    );

    mvw_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (y_coord),
        .divisor  (tol_eff),
        .done     (done_y),
        .quotient (cy)
    );

    mvw_div u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (z_coord),
        .divisor  (tol_eff),
        .done     (done_z),
        .quotient (cz)
    );

    mvw_ram #(
        .WIDTH ($bits(mvw_pkg::mvw_entry_t)),
        .DEPTH (mvw_pkg::MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[mvw_pkg::IDX_W-1:0]),
        .wdata (point),
        .raddr (rd_idx_reg[mvw_pkg::IDX_W-1:0]),
        .rdata (rd_entry)
    );

    mvw_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .tag   (tag_reg),
        .entry (rd_entry),
        .point (point),
        .tol   (tol_reg),
        .tol2  (tol2_reg),
        .best  (best)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mvw_pkg::ST_DIV;
                end
            end
            mvw_pkg::ST_DIV:
            begin
                if (done_x && done_y && done_z)
                begin
                    state_next = mvw_pkg::ST_SCAN;
                end
            end
            mvw_pkg::ST_SCAN:
            begin
                if (rd_idx_reg == count_reg)
                begin
                    state_next = mvw_pkg::ST_DRAIN;
                end
            end
            mvw_pkg::ST_DRAIN:
            begin
                if (!best.busy)
                begin
                    state_next = mvw_pkg::ST_DONE;
                end
            end
            mvw_pkg::ST_DONE:
            begin
                state_next = mvw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mvw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue  = 1'b0;
        commit = 1'b0;
        case (state_reg)
            mvw_pkg::ST_SCAN:
            begin
                issue = (rd_idx_reg != count_reg);
            end
            mvw_pkg::ST_DONE:
            begin
                commit = 1'b1;
            end
            default:
            begin
                issue  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    assign mem_we = commit && !best.found && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mvw_pkg::ST_IDLE;
            weld_tolerance_reg <= mvw_pkg::TOL_RESET;
            count_reg          <= '0;
            rd_idx_reg         <= '0;
            tag_reg            <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tag_reg.valid    <= issue;
            tag_reg.idx      <= rd_idx_reg[mvw_pkg::IDX_W-1:0];
            result_valid_reg <= commit;
            if (weld_tolerance_we)
            begin
                weld_tolerance_reg <= weld_tolerance;
            end
            if (accept)
            begin
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + mvw_pkg::CNT_W'(1);
            end
            if (mem_we)
            begin
                count_reg <= count_reg + mvw_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tol2_reg    <= tol_reg * tol_reg;
        if (accept)
        begin
            px_reg  <= x_coord;
            py_reg  <= y_coord;
            pz_reg  <= z_coord;
            tol_reg <= tol_eff;
        end
        if (commit)
        begin
            if (best.found)
            begin
                vertex_index_reg <= best.idx;
                is_new_reg       <= 1'b0;
                store_full_reg   <= 1'b0;
            end
            else if (full)
            begin
                vertex_index_reg <= '0;
                is_new_reg       <= 1'b0;
                store_full_reg   <= 1'b1;
            end
            else
            begin
                vertex_index_reg <= count_reg[mvw_pkg::IDX_W-1:0];
                is_new_reg       <= 1'b1;
                store_full_reg   <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign vertex_index = vertex_index_reg;
    assign is_new       = is_new_reg;
    assign store_full   = store_full_reg;

    `MVW_ASSERT_NOW(a_result_code, result_valid, !(is_new && store_full), "new and full both set")
    `MVW_ASSERT_NOW(a_no_write_full, mem_we, !full, "store written while full")
    `MVW_ASSERT_NOW(a_new_index, result_valid && is_new, vertex_index == count_reg[mvw_pkg::IDX_W-1:0] - 1'b1, "new index not last stored entry")
    `MVW_ASSERT_NOW(a_drained, state_reg == mvw_pkg::ST_DONE, !best.busy, "commit before match pipeline drained")
    `MVW_ASSERT_NEXT(a_busy_after_accept, accept, busy && !result_valid, "accept did not start work")

endmodule

`default_nettype wire

>>> rtl/core/mvw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/mvw_div.sv
// Iterative floor divider: signed coordinate by unsigned tolerance, one bit per cycle.
// Depends on mvw_pkg.
`default_nettype none

module mvw_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mvw_pkg::COORD_W-1:0]  dividend,
    input  logic [mvw_pkg::TOL_W-1:0]           divisor,
    output logic                                done,
    output logic signed [mvw_pkg::COORD_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(mvw_pkg::COORD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mvw_pkg::COORD_W - 1);

    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             cnt_reg, cnt_next;
    logic                          neg_reg;
    logic [mvw_pkg::COORD_W-1:0]   rem_reg, quo_reg;
    logic [mvw_pkg::TOL_W-1:0]     dvs_reg;
    logic signed [mvw_pkg::COORD_W-1:0] q_reg;

    logic [mvw_pkg::COORD_W-1:0]   trial;
    logic [mvw_pkg::COORD_W-1:0]   dvs_ext;
    logic                          ge;
    logic [mvw_pkg::COORD_W-1:0]   mag;

    assign dvs_ext = mvw_pkg::COORD_W'(dvs_reg);
    assign trial   = {rem_reg[mvw_pkg::COORD_W-2:0], quo_reg[mvw_pkg::COORD_W-1]};
    assign ge      = (trial >= dvs_ext);
    assign mag     = dividend[mvw_pkg::COORD_W-1]
                   ? (mvw_pkg::COORD_W'(~dividend) + mvw_pkg::COORD_W'(1))
                   : mvw_pkg::COORD_W'(dividend);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = fin_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[mvw_pkg::COORD_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - dvs_ext) : trial;
            quo_reg <= {quo_reg[mvw_pkg::COORD_W-2:0], ge};
        end
        if (fin_reg)
        begin
            if (!neg_reg)
            begin
                q_reg <= quo_reg;
            end
            else if (rem_reg != '0)
            begin
                q_reg <= ~quo_reg;
            end
            else
            begin
                q_reg <= mvw_pkg::COORD_W'(0) - quo_reg;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/mvw_match.sv
// Three-stage match pipeline over stored vertices and the best-candidate tracker.
// Depends on mvw_pkg.
`default_nettype none

module mvw_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  mvw_pkg::mvw_tag_t           tag,
    input  mvw_pkg::mvw_entry_t         entry,
    input  mvw_pkg::mvw_entry_t         point,
    input  logic [mvw_pkg::TOL_W-1:0]   tol,
    input  logic [mvw_pkg::SQ_W-1:0]    tol2,
    output mvw_pkg::mvw_best_t          best
);

    localparam int DW = mvw_pkg::COORD_W + 1;

    logic [DW-1:0] ox, oy, oz, ax, ay, az;
    logic          near;
    logic [1:0]    rx, ry, rz;
    logic [mvw_pkg::RANK_W-1:0] rank;

    logic                         a_valid_reg;
    logic [mvw_pkg::IDX_W-1:0]    a_idx_reg;
    logic                         a_near_reg;
    logic [mvw_pkg::RANK_W-1:0]   a_rank_reg;
    logic [mvw_pkg::TOL_W-1:0]    a_ax_reg, a_ay_reg, a_az_reg;

    logic                         b_valid_reg;
    logic [mvw_pkg::IDX_W-1:0]    b_idx_reg;
    logic                         b_near_reg;
    logic [mvw_pkg::RANK_W-1:0]   b_rank_reg;
    logic [mvw_pkg::SQ_W-1:0]     b_sx_reg, b_sy_reg, b_sz_reg;

    logic [mvw_pkg::SUM_W-1:0]    sum;
    logic                         hit;
    logic                         take;

    logic                         found_reg;
    logic [mvw_pkg::IDX_W-1:0]    best_idx_reg;
    logic [mvw_pkg::RANK_W-1:0]   best_rank_reg;

    assign ox = {entry.cx[DW-2], entry.cx} - {point.cx[DW-2], point.cx};
    assign oy = {entry.cy[DW-2], entry.cy} - {point.cy[DW-2], point.cy};
    assign oz = {entry.cz[DW-2], entry.cz} - {point.cz[DW-2], point.cz};
    assign ax = mvw_pkg::abs_diff({point.x[DW-2], point.x} - {entry.x[DW-2], entry.x});
    assign ay = mvw_pkg::abs_diff({point.y[DW-2], point.y} - {entry.y[DW-2], entry.y});
    assign az = mvw_pkg::abs_diff({point.z[DW-2], point.z} - {entry.z[DW-2], entry.z});

    assign near = mvw_pkg::unit_offset(ox) && mvw_pkg::unit_offset(oy)
               && mvw_pkg::unit_offset(oz)
               && (ax <= DW'(tol)) && (ay <= DW'(tol)) && (az <= DW'(tol));

    assign rx   = ox[1:0] + 2'd1;
    assign ry   = oy[1:0] + 2'd1;
    assign rz   = oz[1:0] + 2'd1;
    assign rank = mvw_pkg::RANK_W'(rx) * mvw_pkg::RANK_W'(9)
                + mvw_pkg::RANK_W'(ry) * mvw_pkg::RANK_W'(3)
                + mvw_pkg::RANK_W'(rz);

    assign sum  = mvw_pkg::SUM_W'(b_sx_reg) + mvw_pkg::SUM_W'(b_sy_reg)
                + mvw_pkg::SUM_W'(b_sz_reg);
    assign hit  = b_near_reg && (sum <= mvw_pkg::SUM_W'(tol2));
    assign take = b_valid_reg && hit && (!found_reg || (b_rank_reg < best_rank_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            best_rank_reg <= mvw_pkg::RANK_NONE;
        end
        else
        begin
            a_valid_reg <= tag.valid;
            b_valid_reg <= a_valid_reg;
            if (clear)
            begin
                found_reg     <= 1'b0;
                best_rank_reg <= mvw_pkg::RANK_NONE;
            end
            else if (take)
            begin
                found_reg     <= 1'b1;
                best_rank_reg <= b_rank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg  <= tag.idx;
        a_near_reg <= near;
        a_rank_reg <= rank;
        a_ax_reg   <= ax[mvw_pkg::TOL_W-1:0];
        a_ay_reg   <= ay[mvw_pkg::TOL_W-1:0];
        a_az_reg   <= az[mvw_pkg::TOL_W-1:0];

        b_idx_reg  <= a_idx_reg;
        b_near_reg <= a_near_reg;
        b_rank_reg <= a_rank_reg;
        b_sx_reg   <= a_ax_reg * a_ax_reg;
        b_sy_reg   <= a_ay_reg * a_ay_reg;
        b_sz_reg   <= a_az_reg * a_az_reg;

        if (take)
        begin
            best_idx_reg <= b_idx_reg;
        end
    end

    assign best.busy  = tag.valid | a_valid_reg | b_valid_reg;
    assign best.found = found_reg;
    assign best.idx   = best_idx_reg;

endmodule

`default_nettype wire
